>>> hw/rtl/cts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg: shared definitions for the complex trilinear sampler
// Field widths, register indexes, item modes and the output saturation helper.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int DATA_W    = 32;            // one Q16.16 component
  localparam int ENTRY_W   = 2 * DATA_W;    // imag in the upper half, real in the lower
  localparam int INDEX_W   = 12;
  localparam int STRIDE_W  = 12;
  localparam int FRAC_IN_W = 16;
  localparam int ADDR_W    = INDEX_W + 2;   // base plus three strides
  localparam int MUL_A_W   = DATA_W + 1;    // signed operand of the shared multiplier
  localparam int FIN_W     = 36;            // accumulator width after the final shift
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Z = 2'd2;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [STRIDE_W-1:0] STRIDE_X_RST = 12'd1;
  localparam logic [STRIDE_W-1:0] STRIDE_Y_RST = 12'd16;
  localparam logic [STRIDE_W-1:0] STRIDE_Z_RST = 12'd256;

  // Clamp a shifted sum to the signed 32-bit range.
  function automatic logic [DATA_W-1:0] sat32(input logic signed [FIN_W-1:0] v);
    logic [FIN_W-DATA_W:0] top;
    top = v[FIN_W-1:DATA_W-1];
    if (top == '0 || top == '1) begin
      sat32 = v[DATA_W-1:0];
    end else if (v[FIN_W-1]) begin
      sat32 = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> hw/rtl/cts_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_store: field sample memory
// One write port and one registered read port over the complex entries.
// ----------------------------------------------------------------------------
module cts_store import cts_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/cts_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_mul: shared signed multiplier
// Registered product; an operand pair issued in one cycle is ready in the next.
// ----------------------------------------------------------------------------
module cts_mul #(
  parameter int A_W = 33,
  parameter int B_W = 18
) (
  input  logic                   clk,
  input  logic signed [A_W-1:0]  a,
  input  logic signed [B_W-1:0]  b,
  output logic signed [A_W+B_W-1:0] p
);

  logic signed [A_W+B_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

>>> hw/rtl/complex_trilinear_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_trilinear_sampler: trilinear interpolation over a complex field store
//
// The input channel carries two kinds of beat. A write beat (mode 0) stores
// one complex entry at index in the accepting cycle and returns nothing; the
// block is ready again in the next cycle. A sample beat (mode 1) reads the
// eight cell corners at index plus the configured strides and returns one
// beat with the weighted sum, saturated per component. A corner address past
// the store ends the sample early with out_of_range set and a zero result.
// Each corner takes four passes through one shared multiplier (x-y weight,
// z weight, real term, imaginary term) while the store read runs alongside,
// and the next beat is taken only once the result is loaded into the output
// register, as out_valid rises. One output register parts the channels: a
// stalled receiver holds the result there while new writes are still taken,
// and a second sample waits in its last step until that register frees up.
// Synchronous reset returns the strides to 1, 16 and 256 and drops any
// pending result; the store contents are not cleared and must be written
// before they are sampled. Strides are written through cfg_*; the user must
// do so only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module complex_trilinear_sampler import cts_pkg::*; #(
  parameter int STORE_DEPTH = 4096,
  parameter int FRAC_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STRIDE_W-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [INDEX_W-1:0]   in_index,
  input  logic [DATA_W-1:0]    in_real_in,
  input  logic [DATA_W-1:0]    in_imag_in,
  input  logic [FRAC_IN_W-1:0] in_frac_x,
  input  logic [FRAC_IN_W-1:0] in_frac_y,
  input  logic [FRAC_IN_W-1:0] in_frac_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_real_out,
  output logic [DATA_W-1:0]    out_imag_out,
  output logic                 out_out_of_range
);

  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int WGT_W  = FRAC_BITS + 1;
  localparam int MB_W   = FRAC_BITS + 2;
  localparam int P_W    = MUL_A_W + MB_W;
  localparam int ACC_W  = FRAC_BITS + FIN_W;

  localparam logic [WGT_W-1:0] ONE_W  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [P_W-1:0]   HALF_P = P_W'(1) << (FRAC_BITS - 1);
  localparam logic [ACC_W-1:0] HALF_A = ACC_W'(1) << (FRAC_BITS - 1);

  localparam logic [1:0] PH_XY = 2'd0;
  localparam logic [1:0] PH_Z  = 2'd1;
  localparam logic [1:0] PH_RE = 2'd2;
  localparam logic [1:0] PH_IM = 2'd3;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_LAST, S_OUT} state_t;

  state_t                   state_r;
  logic [1:0]               phase_r;
  logic [2:0]               corner_r;
  logic [INDEX_W-1:0]       base_r;
  logic [FRAC_BITS-1:0]     fx_r, fy_r, fz_r;
  logic [WGT_W-1:0]         w_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r;
  logic                     bad_r;
  logic [STRIDE_W-1:0]      stride_x_r, stride_y_r, stride_z_r;
  logic                     out_valid_r;
  logic [DATA_W-1:0]        real_out_r, imag_out_r;
  logic                     oor_r;

  logic [31:0]              fx_ext, fy_ext, fz_ext, idx_ext, addr_ext;
  logic [WGT_W-1:0]         wx_sel, wy_sel, wz_sel, rnd_w;
  logic [ADDR_W-1:0]        addr_c;
  logic                     addr_bad;
  logic signed [P_W-1:0]    prod, rnd;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic [ENTRY_W-1:0]       rd_data;
  logic [DATA_W-1:0]        ent_re, ent_im;
  logic                     rd_en, wr_en;
  logic signed [ACC_W-1:0]  sum_re, sum_im;
  logic signed [FIN_W-1:0]  fin_re, fin_im;
  logic                     in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign fx_ext  = 32'(in_frac_x);
  assign fy_ext  = 32'(in_frac_y);
  assign fz_ext  = 32'(in_frac_z);
  assign idx_ext = 32'(in_index);

  // Corner bit 0 selects the x neighbor, bit 1 y, bit 2 z.
  assign wx_sel = corner_r[0] ? {1'b0, fx_r} : ONE_W - {1'b0, fx_r};
  assign wy_sel = corner_r[1] ? {1'b0, fy_r} : ONE_W - {1'b0, fy_r};
  assign wz_sel = corner_r[2] ? {1'b0, fz_r} : ONE_W - {1'b0, fz_r};

  assign addr_c = ADDR_W'(base_r)
                + (corner_r[0] ? ADDR_W'(stride_x_r) : '0)
                + (corner_r[1] ? ADDR_W'(stride_y_r) : '0)
                + (corner_r[2] ? ADDR_W'(stride_z_r) : '0);
  assign addr_ext = 32'(addr_c);
  assign addr_bad = (addr_ext >= 32'(STORE_DEPTH));

  // Weight products are non-negative, so the rounded weight is a plain slice.
  assign rnd   = prod + $signed(HALF_P);
  assign rnd_w = rnd[2*FRAC_BITS:FRAC_BITS];

  assign ent_re = rd_data[DATA_W-1:0];
  assign ent_im = rd_data[ENTRY_W-1:DATA_W];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (phase_r)
      PH_XY: begin
        mul_a = $signed(MUL_A_W'(wx_sel));
        mul_b = $signed(MB_W'(wy_sel));
      end
      PH_Z: begin
        mul_a = $signed(MUL_A_W'(rnd_w));
        mul_b = $signed(MB_W'(wz_sel));
      end
      PH_RE: begin
        mul_a = $signed({ent_re[DATA_W-1], ent_re});
        mul_b = $signed(MB_W'(rnd_w));
      end
      PH_IM: begin
        mul_a = $signed({ent_im[DATA_W-1], ent_im});
        mul_b = $signed(MB_W'(w_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rd_en = (state_r == S_RUN) && (phase_r == PH_XY) && !addr_bad;
  assign wr_en = in_acc && (in_mode == MODE_WRITE) && (idx_ext < 32'(STORE_DEPTH));

  assign sum_re = acc_re_r + $signed(HALF_A);
  assign sum_im = acc_im_r + $signed(HALF_A);
  assign fin_re = sum_re[ACC_W-1:FRAC_BITS];
  assign fin_im = sum_im[ACC_W-1:FRAC_BITS];

  cts_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data ({in_imag_in, in_real_in}),
    .rd_en   (rd_en),
    .rd_addr (addr_ext[AW-1:0]),
    .rd_data (rd_data)
  );

  cts_mul #(
    .A_W (MUL_A_W),
    .B_W (MB_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_XY;
      corner_r    <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
      stride_x_r  <= STRIDE_X_RST;
      stride_y_r  <= STRIDE_Y_RST;
      stride_z_r  <= STRIDE_Z_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STRIDE_X: stride_x_r <= cfg_data;
          CFG_STRIDE_Y: stride_y_r <= cfg_data;
          CFG_STRIDE_Z: stride_z_r <= cfg_data;
          default: ;
        endcase
      end

      // In the output step the result register is reloaded instead.
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_mode == MODE_SAMPLE) begin
            base_r   <= in_index;
            fx_r     <= fx_ext[FRAC_BITS-1:0];
            fy_r     <= fy_ext[FRAC_BITS-1:0];
            fz_r     <= fz_ext[FRAC_BITS-1:0];
            acc_re_r <= '0;
            acc_im_r <= '0;
            bad_r    <= 1'b0;
            corner_r <= '0;
            phase_r  <= PH_XY;
            state_r  <= S_RUN;
          end
        end
        S_RUN: begin
          unique case (phase_r)
            PH_XY: begin
              // The previous corner's imaginary term lands here.
              if (corner_r != '0) begin
                acc_im_r <= acc_im_r + ACC_W'(prod);
              end
              if (addr_bad) begin
                bad_r   <= 1'b1;
                state_r <= S_OUT;
              end else begin
                phase_r <= PH_Z;
              end
            end
            PH_Z: begin
              phase_r <= PH_RE;
            end
            PH_RE: begin
              w_r     <= rnd_w;
              phase_r <= PH_IM;
            end
            PH_IM: begin
              acc_re_r <= acc_re_r + ACC_W'(prod);
              phase_r  <= PH_XY;
              if (&corner_r) begin
                state_r <= S_LAST;
              end else begin
                corner_r <= corner_r + 3'd1;
              end
            end
            default: phase_r <= PH_XY;
          endcase
        end
        S_LAST: begin
          acc_im_r <= acc_im_r + ACC_W'(prod);
          state_r  <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            real_out_r  <= bad_r ? '0 : sat32(fin_re);
            imag_out_r  <= bad_r ? '0 : sat32(fin_im);
            oor_r       <= bad_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_real_out     = real_out_r;
  assign out_imag_out     = imag_out_r;
  assign out_out_of_range = oor_r;

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_real_out == '0 && out_imag_out == '0)
    else $error("out-of-range result carries a nonzero value");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_SAMPLE |=> !in_ready)
    else $error("sampler ready right after taking a sample beat");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_WRITE && !out_valid |=> !out_valid)
    else $error("write beat produced a result");

  a_last_after_eight: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LAST |-> $past(state_r) == S_RUN && $past(corner_r) == 3'd7)
    else $error("accumulation finished before all eight corners");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the complex trilinear sampler
// A short table of directed beats hits the value extremes, saturation,
// bilinear cells and a corner past the store. Random cells follow under six
// stride settings and three idle patterns. Every sample beat is checked field
// by field, in order, against the result channel, predicted from a shadow copy
// of the field store or, for typed table rows, taken from the table.
// ----------------------------------------------------------------------------
module tb_top;
  import cts_pkg::*;

  localparam int    STORE_DEPTH   = 4096;
  localparam int    FRAC_BITS     = 16;
  localparam longint FRAC_ONE     = 64'sd1 <<< FRAC_BITS;
  localparam longint FRAC_HALF    = 64'sd1 <<< (FRAC_BITS - 1);
  localparam longint Q_MAX        = 64'sd2147483647;
  localparam longint Q_MIN        = -64'sd2147483648;
  localparam int    SETTLE_CYCLES = 40;
  localparam int    LONG_HOLD     = 500;
  localparam int    ITEMS_PER_HALF = 80;
  localparam logic [DATA_W-1:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MINN = 32'h8000_0000;

  typedef struct packed {
    logic                 mode;
    logic [INDEX_W-1:0]   index;
    logic [DATA_W-1:0]    re;
    logic [DATA_W-1:0]    im;
    logic [FRAC_IN_W-1:0] fx;
    logic [FRAC_IN_W-1:0] fy;
    logic [FRAC_IN_W-1:0] fz;
  } field_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic              oor;
  } sample_t;

  typedef struct packed {
    logic                 mode;
    logic [INDEX_W-1:0]   index;
    logic [DATA_W-1:0]    re;
    logic [DATA_W-1:0]    im;
    logic [FRAC_IN_W-1:0] fx;
    logic [FRAC_IN_W-1:0] fy;
    logic [FRAC_IN_W-1:0] fz;
    logic                 typed;
    logic [DATA_W-1:0]    want_re;
    logic [DATA_W-1:0]    want_im;
    logic                 want_oor;
  } dir_row_t;

  // With the reset strides the cell at entry 0 spans 0, 1, 16, 17, 256, 257,
  // 272 and 273. A fraction pair of 1 and one half rounds all four x-y weights
  // up, so their sum exceeds 1.0 and full-scale corners saturate.
  localparam dir_row_t DIR_TABLE [19] = '{
    '{MODE_WRITE,  12'd0,    MAXP, MINN, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_WRITE,  12'd1,    MAXP, MINN, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_WRITE,  12'd16,   MAXP, MINN, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_WRITE,  12'd17,   MAXP, MINN, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_WRITE,  12'd256,  MAXP, MINN, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_WRITE,  12'd257,  MAXP, MINN, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_WRITE,  12'd272,  MAXP, MINN, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_WRITE,  12'd273,  MAXP, MINN, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_SAMPLE, 12'd0,    '0,   '0,   16'h0000, 16'h0000, 16'h0000, 1'b1, MAXP, MINN, 1'b0},
    '{MODE_SAMPLE, 12'd0,    '0,   '0,   16'h0001, 16'h8000, 16'h0000, 1'b1, MAXP, MINN, 1'b0},
    '{MODE_SAMPLE, 12'd0,    '0,   '0,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0, '0, 1'b0},
    '{MODE_WRITE,  12'd17,   '0,   '0,   16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_WRITE,  12'd272,  32'h0001_0000, 32'hFFFF_0000,
      16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_SAMPLE, 12'd0,    '0,   '0,   16'h8000, 16'h4000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_SAMPLE, 12'd0,    '0,   '0,   16'hFFFF, 16'hFFFF, 16'h8000, 1'b0, '0, '0, 1'b0},
    '{MODE_WRITE,  12'd4095, 32'h1234_5678, 32'hEDCB_A987,
      16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_SAMPLE, 12'd4095, MAXP, MAXP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '0, '0, 1'b1},
    '{MODE_WRITE,  12'd0,    MINN, MAXP, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{MODE_SAMPLE, 12'd0,    '0,   '0,   16'h0000, 16'h0000, 16'h0000, 1'b1, MINN, MAXP, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STRIDE_W-1:0]  cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_mode;
  logic [INDEX_W-1:0]   in_index;
  logic [DATA_W-1:0]    in_real_in;
  logic [DATA_W-1:0]    in_imag_in;
  logic [FRAC_IN_W-1:0] in_frac_x;
  logic [FRAC_IN_W-1:0] in_frac_y;
  logic [FRAC_IN_W-1:0] in_frac_z;
  logic                 out_valid;
  logic                 out_ready;
  logic [DATA_W-1:0]    out_real_out;
  logic [DATA_W-1:0]    out_imag_out;
  logic                 out_out_of_range;

  complex_trilinear_sampler #(
    .STORE_DEPTH(STORE_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_index        (in_index),
    .in_real_in      (in_real_in),
    .in_imag_in      (in_imag_in),
    .in_frac_x       (in_frac_x),
    .in_frac_y       (in_frac_y),
    .in_frac_z       (in_frac_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_real_out    (out_real_out),
    .out_imag_out    (out_imag_out),
    .out_out_of_range(out_out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the field store and the strides the block currently holds.
  logic [ENTRY_W-1:0] field_shadow [STORE_DEPTH];
  bit                 entry_written [STORE_DEPTH];
  int                 stride_x_cur = 1;
  int                 stride_y_cur = 16;
  int                 stride_z_cur = 256;

  sample_t pending_samples [$];
  sample_t got_sample;
  int      mismatches = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      hold_requests = 0;
  int      beats_sent = 0;
  int      n_writes = 0;
  int      n_samples = 0;
  int      n_oor = 0;
  int      n_settings = 1;

  function automatic int corner_addr(input int base, input int c);
    return base + (c[0] ? stride_x_cur : 0) + (c[1] ? stride_y_cur : 0)
           + (c[2] ? stride_z_cur : 0);
  endfunction

  function automatic logic [DATA_W-1:0] round_clamp(input longint acc);
    longint v;
    v = (acc + FRAC_HALF) >>> FRAC_BITS;
    if (v > Q_MAX) begin
      return MAXP;
    end else if (v < Q_MIN) begin
      return MINN;
    end
    return v[DATA_W-1:0];
  endfunction

  // Weighted sum over the eight corners, x fastest, stopping at the first
  // corner that falls past the store.
  function automatic sample_t interpolate_cell(input field_beat_t b);
    longint  wx [2];
    longint  wy [2];
    longint  wz [2];
    longint  wxy, w, acc_re, acc_im;
    int      addr;
    sample_t r;
    wx[1] = b.fx;
    wy[1] = b.fy;
    wz[1] = b.fz;
    wx[0] = FRAC_ONE - wx[1];
    wy[0] = FRAC_ONE - wy[1];
    wz[0] = FRAC_ONE - wz[1];
    acc_re = 0;
    acc_im = 0;
    r = '0;
    for (int c = 0; c < 8; c++) begin
      addr = corner_addr(b.index, c);
      if (addr >= STORE_DEPTH) begin
        r.oor = 1'b1;
        return r;
      end
      wxy = (wx[c[0]] * wy[c[1]] + FRAC_HALF) >>> FRAC_BITS;
      w = (wxy * wz[c[2]] + FRAC_HALF) >>> FRAC_BITS;
      acc_re += longint'($signed(field_shadow[addr][DATA_W-1:0])) * w;
      acc_im += longint'($signed(field_shadow[addr][ENTRY_W-1:DATA_W])) * w;
    end
    r.re = round_clamp(acc_re);
    r.im = round_clamp(acc_im);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_part();
    case ($urandom_range(7))
      0: return MAXP;
      1: return MINN;
      2: return 32'($signed($urandom_range(2 * 65536)) - 65536);
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [FRAC_IN_W-1:0] rand_frac();
    case ($urandom_range(9))
      0: return '0;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h0001;
      default: return FRAC_IN_W'($urandom());
    endcase
  endfunction

  function automatic field_beat_t rand_write(input int addr);
    field_beat_t b;
    b = '0;
    b.mode = MODE_WRITE;
    b.index = INDEX_W'(addr);
    b.re = rand_part();
    b.im = rand_part();
    b.fx = FRAC_IN_W'($urandom());
    b.fy = FRAC_IN_W'($urandom());
    b.fz = FRAC_IN_W'($urandom());
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is
  // taken, with valid still high so a following beat can go out back to back.
  task automatic send_beat(input field_beat_t b, input logic typed, input sample_t want);
    sample_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= b.mode;
    in_index   <= b.index;
    in_real_in <= b.re;
    in_imag_in <= b.im;
    in_frac_x  <= b.fx;
    in_frac_y  <= b.fy;
    in_frac_z  <= b.fz;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (b.mode == MODE_WRITE) begin
      field_shadow[b.index] = {b.im, b.re};
      entry_written[b.index] = 1'b1;
      n_writes++;
    end else begin
      r = typed ? want : interpolate_cell(b);
      pending_samples.push_back(r);
      n_samples++;
      if (r.oor) begin
        n_oor++;
      end
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_strides(input int sx, input int sy, input int sz);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STRIDE_X;
    cfg_data  <= STRIDE_W'(sx);
    @(negedge clk);
    cfg_index <= CFG_STRIDE_Y;
    cfg_data  <= STRIDE_W'(sy);
    @(negedge clk);
    cfg_index <= CFG_STRIDE_Z;
    cfg_data  <= STRIDE_W'(sz);
    @(negedge clk);
    cfg_we <= 1'b0;
    stride_x_cur = sx;
    stride_y_cur = sy;
    stride_z_cur = sz;
    n_settings++;
    @(negedge clk);
  endtask

  // Mostly whole cells: any corner not yet in the store is written first,
  // then the cell is sampled. The rest are stray writes anywhere.
  task automatic run_cells(input int n_beats);
    field_beat_t b;
    int          start, base, span, addr;
    start = beats_sent;
    while (beats_sent - start < n_beats) begin
      if ($urandom_range(99) < 12) begin
        send_beat(rand_write($urandom_range(STORE_DEPTH - 1)), 1'b0, '0);
      end else begin
        span = stride_x_cur + stride_y_cur + stride_z_cur;
        if (span < STORE_DEPTH && $urandom_range(99) < 85) begin
          base = $urandom_range(STORE_DEPTH - 1 - span);
        end else begin
          base = $urandom_range(STORE_DEPTH - 1);
        end
        for (int c = 0; c < 8; c++) begin
          addr = corner_addr(base, c);
          if (addr >= STORE_DEPTH) begin
            break;
          end
          if (!entry_written[addr]) begin
            send_beat(rand_write(addr), 1'b0, '0);
          end
        end
        b = rand_write(base);
        b.mode = MODE_SAMPLE;
        b.fx = rand_frac();
        b.fy = rand_frac();
        b.fz = ($urandom_range(4) == 0) ? '0 : rand_frac();
        send_beat(b, 1'b0, '0);
      end
    end
  endtask

  // Receiver: random back-pressure, plus a long hold whenever one is asked.
  initial begin
    int hold_left;
    int holds_seen;
    hold_left = 0;
    holds_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with no sample pending, expected none, got %h %h %b",
                 $time, out_real_out, out_imag_out, out_out_of_range);
      end else begin
        got_sample = pending_samples.pop_front();
        check_field("real_out", got_sample.re, out_real_out);
        check_field("imag_out", got_sample.im, out_imag_out);
        check_field("out_of_range", DATA_W'(got_sample.oor), DATA_W'(out_out_of_range));
      end
    end
  end

  initial begin
    field_beat_t b;
    sample_t     want;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_STRIDE_X;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_mode    = MODE_WRITE;
    in_index   = '0;
    in_real_in = '0;
    in_imag_in = '0;
    in_frac_x  = '0;
    in_frac_y  = '0;
    in_frac_z  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: write_strides(0, 0, 0);
        2: write_strides(4095, 4095, 4095);
        3: write_strides($urandom_range(8), $urandom_range(64), $urandom_range(1024));
        4: write_strides(1, 64, 2048);
        5: write_strides($urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
        default: ;
      endcase
      tx_idle_pct = (p < 2) ? 16 : (p < 4) ? 78 : 0;
      rx_idle_pct = (p < 2) ? 78 : (p < 4) ? 16 : 0;

      if (p == 0) begin
        foreach (DIR_TABLE[i]) begin
          b = '{DIR_TABLE[i].mode, DIR_TABLE[i].index, DIR_TABLE[i].re, DIR_TABLE[i].im,
                DIR_TABLE[i].fx, DIR_TABLE[i].fy, DIR_TABLE[i].fz};
          want = '{DIR_TABLE[i].want_re, DIR_TABLE[i].want_im, DIR_TABLE[i].want_oor};
          send_beat(b, DIR_TABLE[i].typed, want);
        end
      end

      run_cells(ITEMS_PER_HALF);
      if (p == 0) begin
        // Stall the result side for a long stretch while beats keep coming.
        hold_requests++;
      end else if (p == 2) begin
        wait_idle();
      end
      run_cells(ITEMS_PER_HALF);
    end

    wait_idle();
    $display("Sent %0d beats: %0d writes and %0d samples, %0d of them past the store.",
             beats_sent, n_writes, n_samples, n_oor);
    $display("Ran %0d stride settings under three idle patterns and one long output stall.",
             n_settings);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d samples still pending.", pending_samples.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
